>>> sv/ultrasonic_echo_ranger_unit_defines.svh
// Assertion macros shared by the ranger checker.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define UER_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> sv/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
`timescale 1ns / 1ps
package uer_pkg;

	localparam int TICKS_PER_MS    = 1000;
	localparam int TRIG_LOW_TICKS  = 5;
	localparam int TRIG_HIGH_TICKS = 10;
	localparam int GAP_MAX         = 255;
	localparam int GAP_TICKS_MAX   = GAP_MAX * TICKS_PER_MS;
	localparam int TICK_W          = (GAP_TICKS_MAX > 65536) ? $clog2(GAP_TICKS_MAX + 1) : 17;

	localparam int DIST_W     = 17;
	localparam int PW_W       = 16;
	localparam int CNT_W      = 8;
	localparam int SUM_W      = 25;
	localparam int SPEED_W    = 19;
	localparam int DIVIDEND_W = PW_W + SPEED_W;
	localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// 200000 = 2^6 * 3125; floor(x / 3125) = (x * RECIP_3125) >> 41 for every x below 2^29
	localparam int SAMPLE_SHIFT = 6;
	localparam int SCALED_W     = DIVIDEND_W - SAMPLE_SHIFT;
	localparam int RECIP_W      = 30;
	localparam int RECIP_FRAC   = 41;
	localparam int RECIP_PROD_W = SCALED_W + RECIP_W;

	localparam logic [DIST_W-1:0]  DIST_MAX   = '1;
	localparam logic [PW_W-1:0]    PW_MAX     = '1;
	localparam logic [RECIP_W-1:0] RECIP_3125 = 30'd703687442;
	localparam logic signed [19:0] SPEED_BASE = 20'sd331300;
	localparam logic signed [10:0] SPEED_SLOPE = 11'sd606;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOECHO = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_TEMP    = 3'd0,
		REG_MIN     = 3'd1,
		REG_MAX     = 3'd2,
		REG_TIMEOUT = 3'd3,
		REG_COUNT   = 3'd4,
		REG_GAP     = 3'd5
	} reg_idx_t;

	localparam logic [7:0]        RST_TEMP    = 8'd20;
	localparam logic [DIST_W-1:0] RST_MIN     = 17'd2000;
	localparam logic [DIST_W-1:0] RST_MAX     = 17'd60000;
	localparam logic [15:0]       RST_TIMEOUT = 16'd30000;
	localparam logic [CNT_W-1:0]  RST_COUNT   = 8'd1;
	localparam logic [7:0]        RST_GAP     = 8'd0;

	typedef struct packed {
		logic [7:0]        temperature_c;
		logic [DIST_W-1:0] min_distance;
		logic [DIST_W-1:0] max_distance;
		logic [15:0]       echo_timeout;
		logic [CNT_W-1:0]  sample_count;
		logic [7:0]        gap_ms;
	} cfg_t;

	typedef struct packed {
		logic cap;
		logic step;
		logic mul;
		logic scale;
		logic div_go;
		logic acc;
		logic samp;
		logic fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic finish;
		logic need_dist;
		logic last;
		logic no_valid;
		logic div_busy;
	} sts_t;

endpackage

>>> sv/ultrasonic_echo_ranger_unit.sv
// Top level of the temperature-compensated ultrasonic echo ranger.
// Each tick word (start_req, echo) yields exactly one result word (trigger, busy_res,
// done_res, distance, status). A tick that ends no sample passes through accept, step and
// result load; a tick that ends a sample without an echo or ends a burst with no valid
// sample adds the sample update, and a tick that ends a sample with an echo also forms
// the 16x19 product, scales it by 1/200000, done as a shift and a reciprocal
// multiplication, and accumulates it. A tick that closes a burst with at least one
// valid sample then runs the restoring divider for the average, which yields one
// quotient bit per cycle over the 25-bit sum. The result word sits in an output
// register, so the next tick word is taken while it waits; a held result stalls the next
// word only at its result load. Registers sit at byte offsets 0x00 temperature_c, 0x04
// min_distance, 0x08 max_distance, 0x0C echo_timeout, 0x10 sample_count, 0x14 gap_ms;
// write them only while no burst runs.
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_unit import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  logic              start_req,
	input  logic              echo,
	output logic              res_valid,
	input  logic              res_stall,
	output logic              trigger,
	output logic              busy_res,
	output logic              done_res,
	output logic [DIST_W-1:0] distance,
	output logic [1:0]        status
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	uer_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	uer_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	uer_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_req (start_req),
		.echo      (echo),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.trigger   (trigger),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.distance  (distance),
		.status    (status)
	);

endmodule

>>> sv/uer_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module uer_regs import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temperature_c <= RST_TEMP;
			cfg_q.min_distance  <= RST_MIN;
			cfg_q.max_distance  <= RST_MAX;
			cfg_q.echo_timeout  <= RST_TIMEOUT;
			cfg_q.sample_count  <= RST_COUNT;
			cfg_q.gap_ms        <= RST_GAP;
		end else if (wr) begin
			unique case (idx)
				REG_TEMP:    cfg_q.temperature_c <= pwdata[7:0];
				REG_MIN:     cfg_q.min_distance  <= pwdata[DIST_W-1:0];
				REG_MAX:     cfg_q.max_distance  <= pwdata[DIST_W-1:0];
				REG_TIMEOUT: cfg_q.echo_timeout  <= pwdata[15:0];
				REG_COUNT:   cfg_q.sample_count  <= pwdata[CNT_W-1:0];
				REG_GAP:     cfg_q.gap_ms        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TEMP:    prdata = DATA_W'(cfg_q.temperature_c);
			REG_MIN:     prdata = DATA_W'(cfg_q.min_distance);
			REG_MAX:     prdata = DATA_W'(cfg_q.max_distance);
			REG_TIMEOUT: prdata = DATA_W'(cfg_q.echo_timeout);
			REG_COUNT:   prdata = DATA_W'(cfg_q.sample_count);
			REG_GAP:     prdata = DATA_W'(cfg_q.gap_ms);
			default:     prdata = '0;
		endcase
	end

endmodule

>>> sv/uer_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module uer_div import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              busy,
	output logic [SUM_W-1:0]  quotient
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W:0]       shifted;
	logic                 fits;

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;
	assign shifted  = {rem_q, quo_q[SUM_W-1]};
	assign fits     = (shifted >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(SUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy) begin
			rem_q <= fits ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

endmodule

>>> sv/uer_dp.sv
// Ranger datapath: sample phase logic, distance math, burst averaging, result word.
`timescale 1ns / 1ps
module uer_dp import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_req,
	input  logic              echo,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic              trigger,
	output logic              busy_res,
	output logic              done_res,
	output logic [DIST_W-1:0] distance,
	output logic [1:0]        status
);

	typedef enum logic [2:0] {
		P_IDLE  = 3'd0,
		P_LOW   = 3'd1,
		P_HIGH  = 3'd2,
		P_WAIT  = 3'd3,
		P_PULSE = 3'd4,
		P_GAP   = 3'd5
	} phase_t;

	phase_t                phase_q;
	logic [TICK_W-1:0]     tick_q;
	logic [PW_W-1:0]       pw_q;
	logic [CNT_W-1:0]      samples_q;
	logic [CNT_W-1:0]      valid_q;
	logic [SUM_W-1:0]      sum_q;

	logic                  start_q;
	logic                  echo_q;
	logic [SPEED_W-1:0]    speed_q;
	logic [DIVIDEND_W-1:0] prod_q;
	logic [DIST_W-1:0]     samp_dist_q;
	logic                  trig_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIST_W-1:0]     dist_q;
	status_t               stat_q;

	logic                  trig_out_q;
	logic                  busy_out_q;
	logic                  done_out_q;
	logic [DIST_W-1:0]     dist_out_q;
	status_t               stat_out_q;

	phase_t                ph;
	logic [TICK_W-1:0]     tk;
	logic [PW_W-1:0]       pw;
	logic                  clr;
	logic                  busy_c;
	logic                  trig_c;
	logic                  fin_c;
	logic                  vld_c;
	logic [TICK_W-1:0]     gap_ticks;
	logic signed [18:0]    tmul;
	logic signed [19:0]    speed_c;
	logic [DIVIDEND_W-1:0] prod_c;
	logic [SCALED_W-1:0]   prod_shr;
	logic [RECIP_PROD_W-1:0] recip_c;
	logic [CNT_W-1:0]      samples_inc;
	logic                  last_c;
	logic                  div_busy;
	logic [SUM_W-1:0]      quot;
	logic [DIST_W-1:0]     sample_dist;
	logic [DIST_W-1:0]     avg;

	assign gap_ticks   = TICK_W'(cfg.gap_ms * TICKS_PER_MS);
	assign tmul        = $signed(cfg.temperature_c) * SPEED_SLOPE;
	assign speed_c     = SPEED_BASE + {tmul[18], tmul};
	assign prod_c      = pw_q * speed_q;
	assign prod_shr    = prod_q[DIVIDEND_W-1:SAMPLE_SHIFT];
	assign recip_c     = prod_shr * RECIP_3125;
	assign samples_inc = samples_q + 1'b1;
	assign last_c      = (samples_inc >= cfg.sample_count) || (cfg.sample_count == '0);
	assign sample_dist = (|recip_c[RECIP_PROD_W-1:RECIP_FRAC+DIST_W]) ? DIST_MAX
		: recip_c[RECIP_FRAC+DIST_W-1:RECIP_FRAC];
	assign avg         = quot[DIST_W-1:0];

	always_comb begin
		ph     = phase_q;
		tk     = tick_q;
		pw     = pw_q;
		clr    = 1'b0;
		busy_c = 1'b1;
		trig_c = 1'b0;
		fin_c  = 1'b0;
		vld_c  = 1'b0;
		if (ph == P_IDLE) begin
			if (start_q) begin
				ph  = P_LOW;
				tk  = '0;
				clr = 1'b1;
			end else begin
				busy_c = 1'b0;
			end
		end
		unique case (ph)
			P_LOW: begin
				tk = tk + 1'b1;
				if (tk >= TICK_W'(TRIG_LOW_TICKS)) begin
					ph = P_HIGH;
					tk = '0;
				end
			end
			P_HIGH: begin
				trig_c = 1'b1;
				tk = tk + 1'b1;
				if (tk >= TICK_W'(TRIG_HIGH_TICKS)) begin
					ph = P_WAIT;
					tk = '0;
					pw = '0;
				end
			end
			P_WAIT: begin
				tk = tk + 1'b1;
				if (echo_q) begin
					pw = PW_W'(1);
					ph = P_PULSE;
				end
				if (tk >= TICK_W'(cfg.echo_timeout)) fin_c = 1'b1;
			end
			P_PULSE: begin
				tk = tk + 1'b1;
				if (!echo_q) begin
					fin_c = 1'b1;
					vld_c = 1'b1;
				end else begin
					if (pw != PW_MAX) pw = pw + 1'b1;
					if (tk >= TICK_W'(cfg.echo_timeout)) fin_c = 1'b1;
				end
			end
			P_GAP: begin
				tk = tk + 1'b1;
				if (tk >= gap_ticks) begin
					ph = P_LOW;
					tk = '0;
				end
			end
			default: ;
		endcase
		if (fin_c) tk = '0;
	end

	assign sts.finish    = fin_c;
	assign sts.need_dist = fin_c && vld_c && (pw != '0);
	assign sts.last      = last_c;
	assign sts.no_valid  = (valid_q == '0);
	assign sts.div_busy  = div_busy;

	uer_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (sum_q),
		.divisor  (valid_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= P_IDLE;
			tick_q    <= '0;
			pw_q      <= '0;
			samples_q <= '0;
			valid_q   <= '0;
			sum_q     <= '0;
		end else if (cmd.step) begin
			phase_q <= ph;
			tick_q  <= tk;
			pw_q    <= pw;
			if (clr) begin
				samples_q <= '0;
				valid_q   <= '0;
				sum_q     <= '0;
			end
		end else if (cmd.acc) begin
			sum_q   <= sum_q + SUM_W'(samp_dist_q);
			valid_q <= valid_q + 1'b1;
		end else if (cmd.samp) begin
			samples_q <= samples_inc;
			if (last_c) phase_q <= P_IDLE;
			else phase_q <= (cfg.gap_ms == '0) ? P_LOW : P_GAP;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			start_q <= start_req;
			echo_q  <= echo;
		end
		if (cmd.step) begin
			speed_q <= speed_c[SPEED_W-1:0];
			trig_q  <= trig_c;
			busy_q  <= busy_c;
			done_q  <= 1'b0;
			dist_q  <= '0;
			stat_q  <= ST_OK;
		end
		if (cmd.mul) prod_q <= prod_c;
		if (cmd.scale) samp_dist_q <= sample_dist;
		if (cmd.samp && last_c) begin
			done_q <= 1'b1;
			if (valid_q == '0) stat_q <= ST_NOECHO;
		end
		if (cmd.fin) begin
			dist_q <= avg;
			stat_q <= (avg < cfg.min_distance || avg > cfg.max_distance) ? ST_RANGE : ST_OK;
		end
		if (cmd.emit) begin
			trig_out_q <= trig_q;
			busy_out_q <= busy_q;
			done_out_q <= done_q;
			dist_out_q <= dist_q;
			stat_out_q <= stat_q;
		end
	end

	assign trigger  = trig_out_q;
	assign busy_res = busy_out_q;
	assign done_res = done_out_q;
	assign distance = dist_out_q;
	assign status   = stat_out_q;

endmodule

>>> sv/uer_ctrl.sv
// Ranger controller: sequences one tick word through step, distance and average.
`timescale 1ns / 1ps
module uer_ctrl import uer_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tick_valid,
	output logic tick_stall,
	output logic res_valid,
	input  logic res_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		C_READY,
		C_STEP,
		C_MUL,
		C_SCALE,
		C_ACC,
		C_SAMP,
		C_DIVA_GO,
		C_DIVA_WAIT,
		C_FIN,
		C_EMIT
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   out_free;

	assign out_free   = !res_valid_q || !res_stall;
	assign tick_stall = (state_q != C_READY);
	assign res_valid  = res_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			C_READY:   cmd.cap = tick_valid;
			C_STEP:    cmd.step = 1'b1;
			C_MUL:     cmd.mul = 1'b1;
			C_SCALE:   cmd.scale = 1'b1;
			C_ACC:     cmd.acc = 1'b1;
			C_SAMP:    cmd.samp = 1'b1;
			C_DIVA_GO: cmd.div_go = 1'b1;
			C_FIN:     cmd.fin = 1'b1;
			C_EMIT:    cmd.emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_READY;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				C_READY:     if (tick_valid) state_q <= C_STEP;
				C_STEP: begin
					if (!sts.finish) state_q <= C_EMIT;
					else if (sts.need_dist) state_q <= C_MUL;
					else state_q <= C_SAMP;
				end
				C_MUL:       state_q <= C_SCALE;
				C_SCALE:     state_q <= C_ACC;
				C_ACC:       state_q <= C_SAMP;
				C_SAMP: begin
					if (sts.last && !sts.no_valid) state_q <= C_DIVA_GO;
					else state_q <= C_EMIT;
				end
				C_DIVA_GO:   state_q <= C_DIVA_WAIT;
				C_DIVA_WAIT: if (!sts.div_busy) state_q <= C_FIN;
				C_FIN:       state_q <= C_EMIT;
				C_EMIT:      if (out_free) state_q <= C_READY;
				default:     state_q <= C_READY;
			endcase
		end
	end

endmodule

>>> sv/uer_chk.sv
// Port-level checker for the ranger and its bind.
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_unit_defines.svh"
module uer_chk import uer_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_stall,
	input logic              trigger,
	input logic              busy_res,
	input logic              done_res,
	input logic [DIST_W-1:0] distance,
	input logic [1:0]        status
);

	`UER_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(distance) && $stable(status) && $stable(done_res), "stalled result word changed")
	`UER_ASSERT_SAME(a_trig_busy, res_valid && trigger, busy_res && !done_res, "trigger outside a running burst")
	`UER_ASSERT_SAME(a_quiet_word, res_valid && !done_res, status == ST_OK && distance == '0, "status or distance off a done word")
	`UER_ASSERT_SAME(a_noecho, res_valid && done_res && status == ST_NOECHO, busy_res && distance == '0, "no-echo result with distance")

endmodule

bind ultrasonic_echo_ranger_unit uer_chk u_chk (.*);
